// ----- rtl/rbdq_pkg.sv -----
// Shared constants, codes and types of the dual run queue.
`default_nettype none
package rbdq_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int ID_W       = 8;
   localparam int ROUND_W    = 32;
   localparam int TOTAL_W    = 7;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
   localparam int SUM_W      = (LEN_W + 1 > TOTAL_W) ? LEN_W + 1 : TOTAL_W;

   typedef enum logic [1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_CHOOSE  = 2'd1,
      KIND_STEAL   = 2'd2,
      KIND_REMOVE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ROW_HOLD,
      ROW_PUSH_HEAD,
      ROW_PUSH_TAIL,
      ROW_UNLINK
   } row_op_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_NEXT,
      CELL_TAKE_PREV,
      CELL_TAKE_NEW
   } cell_sel_type;

   typedef struct packed {
      row_op_type        op;
      logic [IDX_W-1:0]  pos;
      logic [ID_W-1:0]   id;
   } row_cmd_type;

endpackage
`default_nettype wire

// ----- rtl/rbdq_ifs.sv -----
// Request and response channel interfaces of the dual run queue.
`default_nettype none
interface rbdq_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    kind;
   logic [rbdq_pkg::ID_W-1:0]     thread_id;
   logic [rbdq_pkg::ROUND_W-1:0]  thread_round;
   logic                          tail_insert;
   logic [rbdq_pkg::ROUND_W-1:0]  global_round;

   modport source (output valid, kind, thread_id, thread_round, tail_insert, global_round,
                   input ready);
   modport sink   (input valid, kind, thread_id, thread_round, tail_insert, global_round,
                   output ready);
endinterface

interface rbdq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          thread_valid;
   logic [rbdq_pkg::ID_W-1:0]     picked_thread;
   logic [rbdq_pkg::ROUND_W-1:0]  stamp_round;
   logic [rbdq_pkg::ROUND_W-1:0]  new_global_round;
   logic                          removed;
   logic                          overflow;
   logic [rbdq_pkg::TOTAL_W-1:0]  queued_total;
   logic                          preempt_request;

   modport source (output valid, thread_valid, picked_thread, stamp_round, new_global_round,
                   removed, overflow, queued_total, preempt_request,
                   input ready);
   modport sink   (input valid, thread_valid, picked_thread, stamp_round, new_global_round,
                   removed, overflow, queued_total, preempt_request,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/round_based_dual_run_queue.sv -----
// Top level of the per-processor dual run queue.
//
// Run queue with an active and an expired list of thread ids and a round
// number. Each list is a chain of LIST_DEPTH cells that shift toward the head
// on a pop or unlink and toward the tail on a head insert. One request is
// handled at a time. Enqueue, choose and steal each run through the execute
// and done states. Remove walks the active list and then the expired list one
// cell per cycle through a single read port per row, with an end check of its
// own after each list, and stops at the first hit. The response sits in an
// output register, so a new request is taken while an earlier response still
// waits for its transfer. No clearing pass follows reset: list slots past the
// length are never read.
`default_nettype none
module round_based_dual_run_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   rbdq_req_if.sink          req_chan,
   rbdq_rsp_if.source        rsp_chan
);

   localparam int DEPTH = rbdq_pkg::LIST_DEPTH;
   localparam int IDX_W = rbdq_pkg::IDX_W;
   localparam int LEN_W = rbdq_pkg::LEN_W;
   localparam int ID_W  = rbdq_pkg::ID_W;
   localparam int RND_W = rbdq_pkg::ROUND_W;
   localparam int SUM_W = rbdq_pkg::SUM_W;

   // control state
   rbdq_pkg::state_type state_ff, state_in;
   logic [LEN_W-1:0]    len_zero_ff, len_zero_in;
   logic [LEN_W-1:0]    len_one_ff, len_one_in;
   logic                act_ff, act_in;
   logic [RND_W-1:0]    round_ff, round_in;
   logic                phase_ff, phase_in;
   logic [LEN_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request held for execution
   rbdq_pkg::kind_type  ex_kind_ff;
   logic [ID_W-1:0]     ex_id_ff;
   logic [RND_W-1:0]    ex_tround_ff;
   logic                ex_tail_ff;
   logic [RND_W-1:0]    ex_ground_ff;

   // pending result, then the output register
   logic                res_valid_ff, res_valid_in;
   logic [ID_W-1:0]     res_picked_ff, res_picked_in;
   logic [RND_W-1:0]    res_stamp_ff, res_stamp_in;
   logic [RND_W-1:0]    res_global_ff, res_global_in;
   logic                res_removed_ff, res_removed_in;
   logic                res_ovf_ff, res_ovf_in;

   logic                o_valid_ff;
   logic [ID_W-1:0]     o_picked_ff;
   logic [RND_W-1:0]    o_stamp_ff;
   logic [RND_W-1:0]    o_global_ff;
   logic                o_removed_ff;
   logic                o_ovf_ff;
   logic [rbdq_pkg::TOTAL_W-1:0] o_total_ff;
   logic                o_preempt_ff;

   // row ports
   rbdq_pkg::row_cmd_type row_zero_cmd, row_one_cmd;
   logic [ID_W-1:0]     head_zero, head_one, rd_zero, rd_one;

   // shared decode
   logic                req_xfer;
   logic                out_free;
   logic [LEN_W-1:0]    len_act, len_exp;
   logic [RND_W-1:0]    enq_round;
   logic                enq_tgt;
   logic [LEN_W-1:0]    enq_len;
   logic                enq_ovf;
   logic                adv;
   logic [RND_W-1:0]    round_sat;
   logic [RND_W-1:0]    pop_round;
   logic                pop_phys;
   logic [LEN_W-1:0]    pop_len;
   logic                scan_phys;
   logic [LEN_W-1:0]    scan_len;
   logic                scan_end;
   logic                scan_hit;
   logic [SUM_W-1:0]    total_sum;

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign len_act   = act_ff ? len_one_ff : len_zero_ff;
   assign len_exp   = act_ff ? len_zero_ff : len_one_ff;

   // enqueue: adopt the global round when both lists are empty
   assign enq_round = (len_zero_ff == '0 && len_one_ff == '0) ? ex_ground_ff : round_ff;
   assign enq_tgt   = (ex_tround_ff < enq_round) ? act_ff : !act_ff;
   assign enq_len   = enq_tgt ? len_one_ff : len_zero_ff;
   assign enq_ovf   = (enq_len >= LEN_W'(DEPTH));

   // steal with empty active and non-empty expired swaps and advances
   assign adv       = (ex_kind_ff == rbdq_pkg::KIND_STEAL) && (len_act == '0) &&
                      (len_exp != '0);
   assign round_sat = (round_ff == '1) ? round_ff : round_ff + RND_W'(1);
   assign pop_round = adv ? round_sat : round_ff;
   assign pop_phys  = adv ? !act_ff : act_ff;
   assign pop_len   = pop_phys ? len_one_ff : len_zero_ff;

   // remove scan: active list first, then expired
   assign scan_phys = act_ff ^ phase_ff;
   assign scan_len  = scan_phys ? len_one_ff : len_zero_ff;
   assign scan_end  = (scan_idx_ff >= scan_len);
   assign scan_hit  = !scan_end && ((scan_phys ? rd_one : rd_zero) == ex_id_ff);

   assign total_sum = SUM_W'(len_zero_ff) + SUM_W'(len_one_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbdq_pkg::ST_IDLE:
            if (req_xfer) begin
               state_in = rbdq_pkg::ST_EXEC;
            end
         rbdq_pkg::ST_EXEC:
            state_in = (ex_kind_ff == rbdq_pkg::KIND_REMOVE) ? rbdq_pkg::ST_SCAN
                                                             : rbdq_pkg::ST_DONE;
         rbdq_pkg::ST_SCAN:
            if (scan_hit || (scan_end && phase_ff)) begin
               state_in = rbdq_pkg::ST_DONE;
            end
         rbdq_pkg::ST_DONE:
            if (out_free) begin
               state_in = rbdq_pkg::ST_IDLE;
            end
         default:
            state_in = rbdq_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      row_zero_cmd   = '{op: rbdq_pkg::ROW_HOLD, pos: '0, id: ex_id_ff};
      row_one_cmd    = '{op: rbdq_pkg::ROW_HOLD, pos: '0, id: ex_id_ff};
      len_zero_in    = len_zero_ff;
      len_one_in     = len_one_ff;
      act_in         = act_ff;
      round_in       = round_ff;
      phase_in       = phase_ff;
      scan_idx_in    = scan_idx_ff;
      res_valid_in   = res_valid_ff;
      res_picked_in  = res_picked_ff;
      res_stamp_in   = res_stamp_ff;
      res_global_in  = res_global_ff;
      res_removed_in = res_removed_ff;
      res_ovf_in     = res_ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         rbdq_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         rbdq_pkg::ST_EXEC: begin
            res_valid_in   = 1'b0;
            res_picked_in  = '0;
            res_stamp_in   = '0;
            res_global_in  = ex_ground_ff;
            res_removed_in = 1'b0;
            res_ovf_in     = 1'b0;
            unique case (ex_kind_ff)
               rbdq_pkg::KIND_ENQUEUE: begin
                  round_in   = enq_round;
                  res_ovf_in = enq_ovf;
                  if (!enq_ovf) begin
                     if (enq_tgt) begin
                        row_one_cmd.op  = ex_tail_ff ? rbdq_pkg::ROW_PUSH_TAIL
                                                     : rbdq_pkg::ROW_PUSH_HEAD;
                        row_one_cmd.pos = enq_len[IDX_W-1:0];
                        len_one_in      = len_one_ff + LEN_W'(1);
                     end else begin
                        row_zero_cmd.op  = ex_tail_ff ? rbdq_pkg::ROW_PUSH_TAIL
                                                      : rbdq_pkg::ROW_PUSH_HEAD;
                        row_zero_cmd.pos = enq_len[IDX_W-1:0];
                        len_zero_in      = len_zero_ff + LEN_W'(1);
                     end
                  end
               end
               rbdq_pkg::KIND_CHOOSE,
               rbdq_pkg::KIND_STEAL: begin
                  act_in   = pop_phys;
                  round_in = pop_round;
                  if (adv && ex_ground_ff < pop_round) begin
                     res_global_in = pop_round;
                  end
                  if (pop_len != '0) begin
                     // pop the head of the (possibly swapped) active list
                     res_valid_in  = 1'b1;
                     res_stamp_in  = pop_round;
                     res_picked_in = pop_phys ? head_one : head_zero;
                     if (pop_phys) begin
                        row_one_cmd.op = rbdq_pkg::ROW_UNLINK;
                        len_one_in     = len_one_ff - LEN_W'(1);
                     end else begin
                        row_zero_cmd.op = rbdq_pkg::ROW_UNLINK;
                        len_zero_in     = len_zero_ff - LEN_W'(1);
                     end
                  end
               end
               rbdq_pkg::KIND_REMOVE: begin
                  phase_in    = 1'b0;
                  scan_idx_in = '0;
               end
               default: begin
               end
            endcase
         end
         rbdq_pkg::ST_SCAN: begin
            if (scan_hit) begin
               res_removed_in = 1'b1;
               if (scan_phys) begin
                  row_one_cmd.op  = rbdq_pkg::ROW_UNLINK;
                  row_one_cmd.pos = scan_idx_ff[IDX_W-1:0];
                  len_one_in      = len_one_ff - LEN_W'(1);
               end else begin
                  row_zero_cmd.op  = rbdq_pkg::ROW_UNLINK;
                  row_zero_cmd.pos = scan_idx_ff[IDX_W-1:0];
                  len_zero_in      = len_zero_ff - LEN_W'(1);
               end
            end else if (scan_end) begin
               // move on to the expired list
               phase_in    = 1'b1;
               scan_idx_in = '0;
            end else begin
               scan_idx_in = scan_idx_ff + LEN_W'(1);
            end
         end
         rbdq_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbdq_pkg::ST_IDLE;
         len_zero_ff  <= '0;
         len_one_ff   <= '0;
         act_ff       <= 1'b0;
         round_ff     <= '0;
         phase_ff     <= 1'b0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_zero_ff  <= len_zero_in;
         len_one_ff   <= len_one_in;
         act_ff       <= act_in;
         round_ff     <= round_in;
         phase_ff     <= phase_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: capture request, pending result, output
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ex_kind_ff   <= rbdq_pkg::kind_type'(req_chan.kind);
         ex_id_ff     <= req_chan.thread_id;
         ex_tround_ff <= req_chan.thread_round;
         ex_tail_ff   <= req_chan.tail_insert;
         ex_ground_ff <= req_chan.global_round;
      end
      res_valid_ff   <= res_valid_in;
      res_picked_ff  <= res_picked_in;
      res_stamp_ff   <= res_stamp_in;
      res_global_ff  <= res_global_in;
      res_removed_ff <= res_removed_in;
      res_ovf_ff     <= res_ovf_in;
      if (state_ff == rbdq_pkg::ST_DONE && out_free) begin
         // list lengths are final here
         o_valid_ff   <= res_valid_ff;
         o_picked_ff  <= res_picked_ff;
         o_stamp_ff   <= res_stamp_ff;
         o_global_ff  <= res_global_ff;
         o_removed_ff <= res_removed_ff;
         o_ovf_ff     <= res_ovf_ff;
         o_total_ff   <= total_sum[rbdq_pkg::TOTAL_W-1:0];
         o_preempt_ff <= (total_sum != '0);
      end
   end

   rbdq_row u_row_zero (
      .clock   (clock),
      .cmd     (row_zero_cmd),
      .rd_idx  (scan_idx_ff[IDX_W-1:0]),
      .head_id (head_zero),
      .rd_id   (rd_zero)
   );

   rbdq_row u_row_one (
      .clock   (clock),
      .cmd     (row_one_cmd),
      .rd_idx  (scan_idx_ff[IDX_W-1:0]),
      .head_id (head_one),
      .rd_id   (rd_one)
   );

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.thread_valid     = o_valid_ff;
   assign rsp_chan.picked_thread    = o_picked_ff;
   assign rsp_chan.stamp_round      = o_stamp_ff;
   assign rsp_chan.new_global_round = o_global_ff;
   assign rsp_chan.removed          = o_removed_ff;
   assign rsp_chan.overflow         = o_ovf_ff;
   assign rsp_chan.queued_total     = o_total_ff;
   assign rsp_chan.preempt_request  = o_preempt_ff;

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_zero_ff <= LEN_W'(DEPTH) && len_one_ff <= LEN_W'(DEPTH))
      else $error("list length beyond depth");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbdq_pkg::ST_EXEC && ex_kind_ff == rbdq_pkg::KIND_ENQUEUE && !enq_ovf)
      |=> (total_sum == $past(total_sum) + SUM_W'(1)))
      else $error("enqueue did not add one thread");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbdq_pkg::ST_SCAN && scan_hit)
      |=> (total_sum + SUM_W'(1) == $past(total_sum)))
      else $error("remove did not unlink one thread");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == rbdq_pkg::ST_SCAN |-> scan_idx_ff <= LEN_W'(DEPTH))
      else $error("scan index past list depth");
`endif

endmodule
`default_nettype wire

// ----- rtl/rbdq_cell.sv -----
// One list slot: holds a thread id and loads from a neighbor or the new id.
`default_nettype none
module rbdq_cell (
   input  wire logic                       clock,
   input  wire rbdq_pkg::cell_sel_type     sel,
   input  wire logic [rbdq_pkg::ID_W-1:0]  prev_id,
   input  wire logic [rbdq_pkg::ID_W-1:0]  next_id,
   input  wire logic [rbdq_pkg::ID_W-1:0]  new_id,
   output      logic [rbdq_pkg::ID_W-1:0]  id
);

   logic [rbdq_pkg::ID_W-1:0] id_ff;
   logic [rbdq_pkg::ID_W-1:0] id_in;

   always_comb begin
      unique case (sel)
         rbdq_pkg::CELL_HOLD:      id_in = id_ff;
         rbdq_pkg::CELL_TAKE_NEXT: id_in = next_id;
         rbdq_pkg::CELL_TAKE_PREV: id_in = prev_id;
         rbdq_pkg::CELL_TAKE_NEW:  id_in = new_id;
         default:                  id_in = id_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;

endmodule
`default_nettype wire

// ----- rtl/rbdq_row.sv -----
// One thread list as a chain of cells with head, tail and unlink shifting.
`default_nettype none
module rbdq_row (
   input  wire logic                        clock,
   input  wire rbdq_pkg::row_cmd_type       cmd,
   input  wire logic [rbdq_pkg::IDX_W-1:0]  rd_idx,
   output      logic [rbdq_pkg::ID_W-1:0]   head_id,
   output      logic [rbdq_pkg::ID_W-1:0]   rd_id
);

   logic [rbdq_pkg::ID_W-1:0] cell_id [rbdq_pkg::LIST_DEPTH];

   for (genvar i = 0; i < rbdq_pkg::LIST_DEPTH; i++) begin : g_cell
      rbdq_pkg::cell_sel_type    sel;
      logic [rbdq_pkg::ID_W-1:0] prev_id;
      logic [rbdq_pkg::ID_W-1:0] next_id;

      if (i == 0) begin : g_first
         assign prev_id = cmd.id;
      end else begin : g_mid
         assign prev_id = cell_id[i-1];
      end

      if (i == rbdq_pkg::LIST_DEPTH - 1) begin : g_last
         assign next_id = cell_id[i];
      end else begin : g_notlast
         assign next_id = cell_id[i+1];
      end

      always_comb begin
         unique case (cmd.op)
            rbdq_pkg::ROW_HOLD:
               sel = rbdq_pkg::CELL_HOLD;
            rbdq_pkg::ROW_PUSH_HEAD:
               sel = (i == 0) ? rbdq_pkg::CELL_TAKE_NEW : rbdq_pkg::CELL_TAKE_PREV;
            rbdq_pkg::ROW_PUSH_TAIL:
               sel = (cmd.pos == rbdq_pkg::IDX_W'(i)) ? rbdq_pkg::CELL_TAKE_NEW
                                                      : rbdq_pkg::CELL_HOLD;
            rbdq_pkg::ROW_UNLINK:
               // close the gap: every slot at or past the removed one, but the last, takes its successor
               sel = (rbdq_pkg::IDX_W'(i) >= cmd.pos && i < rbdq_pkg::LIST_DEPTH - 1)
                     ? rbdq_pkg::CELL_TAKE_NEXT : rbdq_pkg::CELL_HOLD;
            default:
               sel = rbdq_pkg::CELL_HOLD;
         endcase
      end

      rbdq_cell u_cell (
         .clock   (clock),
         .sel     (sel),
         .prev_id (prev_id),
         .next_id (next_id),
         .new_id  (cmd.id),
         .id      (cell_id[i])
      );
   end

   assign head_id = cell_id[0];
   assign rd_id   = cell_id[rd_idx];

endmodule
`default_nettype wire

// ----- tb/sv/tb_round_based_dual_run_queue.sv -----
// Testbench of the dual run queue: a directed table, then random phases checked by a predictor.
`default_nettype none
module tb_round_based_dual_run_queue;
   timeunit 1ns;
   timeprecision 1ps;

   // One request as the sender drives it.
   typedef struct packed {
      rbdq_pkg::kind_type kind;
      logic [7:0]  id;
      logic [31:0] t_round;
      logic        tail;
      logic [31:0] g_round;
   } sched_req_type;

   // One response, field for field as the block returns it.
   typedef struct packed {
      logic        thread_valid;
      logic [7:0]  picked;
      logic [31:0] stamp;
      logic [31:0] new_global;
      logic        removed;
      logic        overflow;
      logic [6:0]  total;
      logic        preempt;
   } sched_verdict_type;

   // A row of the opening table; fixed rows carry their response typed in.
   typedef struct {
      sched_req_type     req;
      bit                fixed;
      sched_verdict_type want;
   } script_row_type;

   // Random phases lean toward one kind of traffic each.
   typedef enum {PH_FILL, PH_DRAIN, PH_MIX, PH_PURGE} phase_type;

   localparam int RANDOM_ITEMS = 1830;
   localparam int SETTLE_CYCLES = 80;

   logic clock = 1'b0;
   logic reset;

   rbdq_req_if req_chan ();
   rbdq_rsp_if rsp_chan ();

   round_based_dual_run_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the run queue: two lists, their lengths, which one is
   // active and the queue round.
   bit [7:0]    rq_ids [2][rbdq_pkg::LIST_DEPTH];
   int unsigned rq_len [2];
   bit          rq_active;
   bit [31:0]   rq_round;

   sched_verdict_type due_verdicts [$];
   script_row_type    script [$];
   int                faults;
   bit                send_idle;
   bit                recv_idle;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Close the gap left by entry k of list sid.
   function automatic void rq_drop(bit sid, int unsigned k);
      int unsigned i;
      for (i = k + 1; i < rq_len[sid]; i++) begin
         rq_ids[sid][i-1] = rq_ids[sid][i];
      end
      rq_len[sid]--;
   endfunction

   // Advance the shadow queue by one request and work out its response.
   function automatic sched_verdict_type runq_apply(sched_req_type r);
      sched_verdict_type v;
      bit             act;
      bit             sid;
      bit             hit;
      int unsigned    k;
      int unsigned    held;
      int             p;
      v = '0;
      v.new_global = r.g_round;
      act = rq_active;
      case (r.kind)
         rbdq_pkg::KIND_ENQUEUE: begin
            // adopt the global round when the queue runs dry
            if (rq_len[0] == 0 && rq_len[1] == 0) rq_round = r.g_round;
            sid = (r.t_round < rq_round) ? act : !act;
            if (rq_len[sid] >= rbdq_pkg::LIST_DEPTH) begin
               v.overflow = 1'b1;
            end else if (r.tail) begin
               rq_ids[sid][rq_len[sid]] = r.id;
               rq_len[sid]++;
            end else begin
               for (k = rq_len[sid]; k > 0; k--) rq_ids[sid][k] = rq_ids[sid][k-1];
               rq_ids[sid][0] = r.id;
               rq_len[sid]++;
            end
         end
         rbdq_pkg::KIND_CHOOSE, rbdq_pkg::KIND_STEAL: begin
            // steal swaps the lists and bumps the round when active ran out
            if (r.kind == rbdq_pkg::KIND_STEAL && rq_len[act] == 0 && rq_len[!act] != 0) begin
               rq_active = !act;
               act = rq_active;
               if (rq_round != 32'hFFFF_FFFF) rq_round++;
               if (v.new_global < rq_round) v.new_global = rq_round;
            end
            if (rq_len[act] != 0) begin
               v.thread_valid = 1'b1;
               v.picked = rq_ids[act][0];
               v.stamp = rq_round;
               rq_drop(act, 0);
            end
         end
         rbdq_pkg::KIND_REMOVE: begin
            // first match wins: active head to tail, then expired
            hit = 1'b0;
            for (p = 0; p < 2 && !hit; p++) begin
               sid = (p == 0) ? act : !act;
               for (k = 0; k < rq_len[sid] && !hit; k++) begin
                  if (rq_ids[sid][k] == r.id) begin
                     rq_drop(sid, k);
                     hit = 1'b1;
                  end
               end
            end
            v.removed = hit;
         end
      endcase
      held = rq_len[0] + rq_len[1];
      v.total = held[6:0];
      v.preempt = (held != 0);
      return v;
   endfunction

   // Draw one random request, shaped by the phase and by the shadow state so
   // that lists fill up, rounds advance and removes hit queued ids.
   function automatic sched_req_type draw_req(phase_type ph, bit lean);
      sched_req_type r;
      int unsigned roll;
      int unsigned w_enq;
      int unsigned w_cho;
      int unsigned w_stl;
      int unsigned held;
      bit          sid;
      bit [31:0]   eff;
      case (ph)
         PH_FILL:  begin w_enq = 80; w_cho = 88; w_stl = 94; end
         PH_DRAIN: begin w_enq = 10; w_cho = 50; w_stl = 90; end
         PH_MIX:   begin w_enq = 35; w_cho = 55; w_stl = 75; end
         default:  begin w_enq = 20; w_cho = 30; w_stl = 40; end
      endcase
      held = rq_len[0] + rq_len[1];
      roll = $urandom_range(0, 99);
      if (roll < w_enq) r.kind = rbdq_pkg::KIND_ENQUEUE;
      else if (roll < w_cho) r.kind = rbdq_pkg::KIND_CHOOSE;
      else if (roll < w_stl) r.kind = rbdq_pkg::KIND_STEAL;
      else r.kind = rbdq_pkg::KIND_REMOVE;

      // a small id pool makes duplicates common
      roll = $urandom_range(0, 99);
      if (roll < 40) r.id = 8'($urandom_range(0, 7));
      else if (roll < 46) r.id = roll[0] ? 8'hFF : 8'h00;
      else r.id = 8'($urandom_range(0, 255));
      if (r.kind == rbdq_pkg::KIND_REMOVE && held != 0 && $urandom_range(0, 9) < 7) begin
         if (rq_len[0] == 0) sid = 1'b1;
         else if (rq_len[1] == 0) sid = 1'b0;
         else sid = 1'($urandom_range(0, 1));
         r.id = rq_ids[sid][$urandom_range(0, rq_len[sid] - 1)];
      end

      roll = $urandom_range(0, 99);
      if (roll < 10) r.g_round = 32'hFFFF_FFFF;
      else if (roll < 15) r.g_round = 32'h0;
      else if (roll < 60) r.g_round = rq_round + 32'($urandom_range(0, 3));
      else r.g_round = $urandom;

      // aim the thread round just below, at or just above the round it meets
      eff = (held == 0) ? r.g_round : rq_round;
      roll = $urandom_range(0, 99);
      if (roll < 10) r.t_round = $urandom;
      else if (roll < 16) r.t_round = roll[0] ? 32'hFFFF_FFFF : 32'h0;
      else if ($urandom_range(0, 9) < (lean ? 7 : 3)) r.t_round = eff - 32'($urandom_range(1, 3));
      else r.t_round = eff + 32'($urandom_range(0, 2));

      r.tail = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic add_row(sched_req_type r, bit fixed, sched_verdict_type want);
      script_row_type row;
      row.req = r;
      row.fixed = fixed;
      row.want = want;
      script.push_back(row);
   endtask

   // Drive one request after a random gap (none when send_idle is clear) and hold it until the transfer.
   task automatic send_item(sched_req_type r, bit fixed, sched_verdict_type want);
      int unsigned       gap;
      sched_verdict_type v;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.kind         <= r.kind;
      req_chan.thread_id    <= r.id;
      req_chan.thread_round <= r.t_round;
      req_chan.tail_insert  <= r.tail;
      req_chan.global_round <= r.g_round;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      v = runq_apply(r);
      due_verdicts.push_back(fixed ? want : v);
   endtask

   // Drop valid and hold off until every pending response has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         faults++;
      end
   endtask

   // Stimulus: reset, the opening table, then random phases.
   initial begin
      sched_verdict_type blank;
      phase_type      ph;
      bit             lean;
      int unsigned    pick;
      int             span;
      int             sent;
      blank = '0;
      faults = 0;
      rq_len[0] = 0;
      rq_len[1] = 0;
      rq_active = 1'b0;
      rq_round = '0;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      reset = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.kind         = rbdq_pkg::KIND_ENQUEUE;
      req_chan.thread_id    = '0;
      req_chan.thread_round = '0;
      req_chan.tail_insert  = 1'b0;
      req_chan.global_round = '0;

      // empty queue: nothing to dispatch or remove, global round echoed
      add_row(sched_req_type'{rbdq_pkg::KIND_CHOOSE, 8'h00, 32'h0, 1'b0, 32'h0000_1234}, 1'b1,
              sched_verdict_type'{1'b0, 8'h00, 32'h0, 32'h0000_1234, 1'b0, 1'b0, 7'd0, 1'b0});
      add_row(sched_req_type'{rbdq_pkg::KIND_STEAL, 8'h00, 32'h0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
              sched_verdict_type'{1'b0, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0, 1'b0});
      add_row(sched_req_type'{rbdq_pkg::KIND_REMOVE, 8'hFF, 32'h0, 1'b0, 32'h0}, 1'b1,
              sched_verdict_type'{1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 7'd0, 1'b0});
      // first enqueue adopts the top global round, so round 0 lands active
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'h00, 32'h0, 1'b1, 32'hFFFF_FFFF}, 1'b1,
              sched_verdict_type'{1'b0, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd1, 1'b1});
      // round not below the queue round goes to the expired list
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0}, 1'b1,
              sched_verdict_type'{1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 7'd2, 1'b1});
      add_row(sched_req_type'{rbdq_pkg::KIND_CHOOSE, 8'h00, 32'h0, 1'b0, 32'h1}, 1'b0, blank);
      // swap with the round stuck at its maximum
      add_row(sched_req_type'{rbdq_pkg::KIND_STEAL, 8'h00, 32'h0, 1'b0, 32'h5}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'h11, 32'h3, 1'b1, 32'hA}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'h22, 32'hA, 1'b0, 32'hA}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'h33, 32'h14, 1'b1, 32'hA}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'h11, 32'h0, 1'b0, 32'hA}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_REMOVE, 8'h22, 32'h0, 1'b0, 32'hA}, 1'b0, blank);
      // duplicate id: only the first match goes
      add_row(sched_req_type'{rbdq_pkg::KIND_REMOVE, 8'h11, 32'h0, 1'b0, 32'hA}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_REMOVE, 8'h44, 32'h0, 1'b0, 32'hA}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_CHOOSE, 8'h00, 32'h0, 1'b0, 32'hA}, 1'b0, blank);
      // choose never swaps, even with the expired list holding threads
      add_row(sched_req_type'{rbdq_pkg::KIND_CHOOSE, 8'h00, 32'h0, 1'b0, 32'hA}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_STEAL, 8'h00, 32'h0, 1'b0, 32'h3}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_STEAL, 8'h00, 32'h0, 1'b0, 32'hC8}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'hAA, 32'h8000_0000, 1'b0,
                              32'h7FFF_FFFF}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_STEAL, 8'h00, 32'h0, 1'b0, 32'h0}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_ENQUEUE, 8'h55, 32'h7FFF_FFFE, 1'b1,
                              32'hFFFF_FFFE}, 1'b0, blank);
      add_row(sched_req_type'{rbdq_pkg::KIND_REMOVE, 8'h55, 32'h0, 1'b0, 32'h0}, 1'b0, blank);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_item(script[i].req, script[i].fixed, script[i].want);
      hold_until_drained();

      // random phases; pause after each until the queue has answered all
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) ph = PH_FILL;
         else if (pick < 6) ph = PH_DRAIN;
         else if (pick < 8) ph = PH_MIX;
         else ph = PH_PURGE;
         lean = 1'($urandom_range(0, 1));
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         span = int'($urandom_range(30, 90));
         if (span > RANDOM_ITEMS - sent) span = RANDOM_ITEMS - sent;
         repeat (span) begin
            send_item(draw_req(ph, lean), 1'b0, blank);
            sent++;
         end
         hold_until_drained();
      end

      // let a slow remove or a stray response show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (faults == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Response side: stall at random, then check each transfer against the
   // oldest pending response.
   initial begin
      int unsigned       stall;
      sched_verdict_type want;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = recv_idle ? $urandom_range(0, 8) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         if (due_verdicts.size() == 0) begin
            $display("%0t: response with nothing pending, expected none, got total 0x%0h",
                     $time, rsp_chan.queued_total);
            faults++;
         end else begin
            want = due_verdicts.pop_front();
            match_field("thread_valid", 32'(want.thread_valid), 32'(rsp_chan.thread_valid));
            match_field("picked_thread", 32'(want.picked), 32'(rsp_chan.picked_thread));
            match_field("stamp_round", want.stamp, rsp_chan.stamp_round);
            match_field("new_global_round", want.new_global, rsp_chan.new_global_round);
            match_field("removed", 32'(want.removed), 32'(rsp_chan.removed));
            match_field("overflow", 32'(want.overflow), 32'(rsp_chan.overflow));
            match_field("queued_total", 32'(want.total), 32'(rsp_chan.queued_total));
            match_field("preempt_request", 32'(want.preempt), 32'(rsp_chan.preempt_request));
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/rbdq_pkg.sv
rtl/rbdq_ifs.sv
rtl/rbdq_cell.sv
rtl/rbdq_row.sv
rtl/round_based_dual_run_queue.sv
tb/sv/tb_round_based_dual_run_queue.sv
